@@ rtl/fps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants for the Fenwick prefix-sum tree.
// ----------------------------------------------------------------------------
package fps_pkg;

    // default tree geometry
    localparam int SIZE_DEF       = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // fixed port widths
    localparam int POS_W   = 10;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 32;

    // item kinds
    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WALK
    } t_state;

    // memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

@@ rtl/fps_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_mem
// Tree node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fps_mem #(
    parameter int SIZE       = fps_pkg::SIZE_DEF,
    parameter int VALUE_BITS = fps_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(SIZE)
) (
    input  logic                  i_clk,
    input  fps_pkg::t_mem_ctl     i_ctl,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [VALUE_BITS-1:0] i_wr_data,
    output logic [VALUE_BITS-1:0] o_rd_data
);
    import fps_pkg::*;

    logic [VALUE_BITS-1:0] r_mem [SIZE];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/fps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_ctrl
// Walk sequencer: clearing pass, node walk (read-modify-write for adds), result.
// ----------------------------------------------------------------------------
module fps_ctrl #(
    parameter int SIZE       = fps_pkg::SIZE_DEF,
    parameter int VALUE_BITS = fps_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(SIZE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [fps_pkg::POS_W-1:0]     i_position,
    input  logic [fps_pkg::DELTA_W-1:0]   i_delta,
    output logic                          o_valid,
    output logic [fps_pkg::SUM_W-1:0]     o_prefix_sum,
    output fps_pkg::t_mem_ctl             o_mem_ctl,
    output logic [AW-1:0]                 o_rd_addr,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [VALUE_BITS-1:0]         o_wr_data,
    input  logic [VALUE_BITS-1:0]         i_rd_data
);
    import fps_pkg::*;

    // node index wide enough for position+1 and for k+lowbit(k) up to 2*SIZE
    localparam int KW = ($clog2(SIZE) + 2 > POS_W + 1) ? $clog2(SIZE) + 2 : POS_W + 1;

    t_state                r_state, n_state;
    t_action               r_act;
    logic [KW-1:0]         r_k;
    logic [VALUE_BITS-1:0] r_delta;
    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_dvalid;
    logic [AW-1:0]         r_waddr;
    logic [AW-1:0]         r_clr;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out;

    logic                  w_accept;
    logic                  w_live;
    logic                  w_done;
    logic                  w_clr_last;
    logic [KW-1:0]         w_low;
    logic [KW-1:0]         w_k_next;
    logic [KW-1:0]         w_k_start;
    logic [KW-1:0]         w_k_m1;
    logic [KW-1:0]         w_pos;
    logic [VALUE_BITS-1:0] w_delta_ext;
    logic [SUM_W-1:0]      w_sum_ext;

    assign w_accept = start && (r_state == ST_IDLE);

    // sign-extend or truncate the delta to the node width
    generate
        if (VALUE_BITS > DELTA_W) begin : g_dext
            assign w_delta_ext = {{(VALUE_BITS - DELTA_W){i_delta[DELTA_W-1]}}, i_delta};
        end else if (VALUE_BITS == DELTA_W) begin : g_deq
            assign w_delta_ext = i_delta;
        end else begin : g_dtrunc
            assign w_delta_ext = i_delta[VALUE_BITS-1:0];
        end
    endgenerate

    // low bits of the accumulator, zero-extended for narrow nodes
    generate
        if (VALUE_BITS > SUM_W) begin : g_strunc
            assign w_sum_ext = r_acc[SUM_W-1:0];
        end else if (VALUE_BITS == SUM_W) begin : g_seq
            assign w_sum_ext = r_acc;
        end else begin : g_sext
            assign w_sum_ext = {{(SUM_W - VALUE_BITS){1'b0}}, r_acc};
        end
    endgenerate

    // starting node: queries saturate to the last position
    assign w_pos = KW'(i_position);
    always_comb begin
        if ((t_action'(i_action) == ACT_QUERY) && (w_pos >= KW'(SIZE))) begin
            w_k_start = KW'(SIZE);
        end else begin
            w_k_start = w_pos + KW'(1);
        end
    end

    // walk step: up by adding the lowest set bit, down by clearing it
    assign w_low    = r_k & (~r_k + KW'(1));
    assign w_k_next = (r_act == ACT_ADD) ? (r_k + w_low) : (r_k - w_low);
    assign w_k_m1   = r_k - KW'(1);
    assign w_live   = (r_act == ACT_ADD) ? (r_k <= KW'(SIZE)) : (r_k != '0);
    assign w_done   = !w_live && !r_dvalid;
    assign w_clr_last = (r_clr == AW'(SIZE - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start)      n_state = ST_WALK;
            ST_CLEAR: if (w_clr_last) n_state = ST_IDLE;
            ST_WALK:  if (w_done)     n_state = ST_IDLE;
            default:                  n_state = ST_IDLE;
        endcase
    end

    // memory strobes and busy
    always_comb begin
        o_mem_ctl = '0;
        o_wr_addr = r_waddr;
        o_wr_data = i_rd_data + r_delta;
        busy      = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_clr;
                o_wr_data       = '0;
            end
            ST_WALK: begin
                o_mem_ctl.rd_en = w_live;
                o_mem_ctl.wr_en = r_dvalid && (r_act == ACT_ADD);
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end
    assign o_rd_addr = w_k_m1[AW-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            r_dvalid    <= (r_state == ST_WALK) && w_live;
            r_out_valid <= (r_state == ST_WALK) && w_done && (r_act == ACT_QUERY);
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= t_action'(i_action);
            r_k     <= w_k_start;
            r_delta <= w_delta_ext;
            r_acc   <= '0;
        end else if (r_state == ST_WALK) begin
            if (w_live) begin
                r_k     <= w_k_next;
                r_waddr <= w_k_m1[AW-1:0];
            end
            if (r_dvalid && (r_act == ACT_QUERY)) begin
                r_acc <= r_acc + i_rd_data;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WALK) && w_done) begin
            r_out <= w_sum_ext;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_prefix_sum = r_out;

endmodule

@@ rtl/fenwick_prefix_sum_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_tree
// Binary indexed tree: point add and prefix-sum query over SIZE positions.
// ----------------------------------------------------------------------------
// Channel  Ports                                    Handshake
// -------  ---------------------------------------  ---------------------------
// in       i_action, i_position, i_delta            start high, busy low
// out      o_prefix_sum                             o_valid, one cycle strobe
//
// An item visiting n nodes holds busy from acceptance until its walk ends;
// n is at most log2(SIZE)+1, so up to 11 nodes at SIZE 1024. The node
// memory has one read and one write port: one node read per cycle, write-back
// overlapped with the next read. A query result strobes in the cycle busy falls.
// After reset a clearing pass zeroes the tree with busy high.
// The receiver cannot stall; results are always taken.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_tree #(
    parameter int SIZE       = fps_pkg::SIZE_DEF,
    parameter int VALUE_BITS = fps_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [fps_pkg::POS_W-1:0]   i_position,
    input  logic [fps_pkg::DELTA_W-1:0] i_delta,
    output logic                        o_valid,
    output logic [fps_pkg::SUM_W-1:0]   o_prefix_sum
);
    import fps_pkg::*;

    localparam int AW = $clog2(SIZE);

    t_mem_ctl              w_mem_ctl;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [VALUE_BITS-1:0] w_wr_data;
    logic [VALUE_BITS-1:0] w_rd_data;

    // sequencer
    fps_ctrl #(
        .SIZE       (SIZE),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_delta      (i_delta),
        .o_valid      (o_valid),
        .o_prefix_sum (o_prefix_sum),
        .o_mem_ctl    (w_mem_ctl),
        .o_rd_addr    (w_rd_addr),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .i_rd_data    (w_rd_data)
    );

    // node store
    fps_mem #(
        .SIZE       (SIZE),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

endmodule

@@ rtl/fps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on the Fenwick prefix-sum tree, bound to the top level.
// ----------------------------------------------------------------------------
module fps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    import fps_pkg::*;

    // reset starts the clearing pass
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // an accepted item always occupies the block next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // a result appears only once the walk has ended
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside walk completion");

    // at most one result per item, never back to back
    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

endmodule

bind fenwick_prefix_sum_tree fps_checker u_fps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
